// File: design/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette colour mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

	localparam int PALETTE_SIZE_DEF = 256;
	localparam int IDX_W            = 8;
	localparam int CH_W             = 8;
	localparam int THR_W            = 9;
	localparam int SQ_W             = 2 * CH_W;
	localparam int DIST_W           = 18;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	typedef struct packed {
		logic              vld;
		logic              pixel;
		logic [IDX_W-1:0]  entry_index;
		logic              entry_valid;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic              transp;
		logic              found;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
	} flow_t;

	function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
	                                            input logic [CH_W-1:0] b);
		logic [CH_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return d * d;
	endfunction

endpackage

// File: design/npcm_if.sv
// ----------------------------------------------------------------------------
// npcm_if
// Request and result channels of the nearest palette colour mapper.
// ----------------------------------------------------------------------------
interface npcm_in_if;
	import npcm_pkg::*;

	logic             valid;
	logic             ready;
	logic             action;
	logic [IDX_W-1:0] entry_index;
	logic             entry_valid;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic [CH_W-1:0]  alpha;

	modport source (output valid, action, entry_index, entry_valid, red, green, blue,
		alpha, input ready);
	modport sink (input valid, action, entry_index, entry_valid, red, green, blue,
		alpha, output ready);
endinterface

interface npcm_out_if;
	import npcm_pkg::*;

	logic              valid;
	logic              ready;
	logic              transparent;
	logic [IDX_W-1:0]  palette_index;
	logic [DIST_W-1:0] distance;
	logic              found;

	modport source (output valid, transparent, palette_index, distance, found,
		input ready);
	modport sink (input valid, transparent, palette_index, distance, found,
		output ready);
endinterface

// File: design/nearest_palette_color_mapper_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_unit
// Chain: a request passes every palette cell in order before its result leaves,
//   two register stages per palette cell in the chain.
// Throughput: one request per cycle while the result side is ready; a stalled
//   result freezes the whole chain.
// Reset: clears every valid mark and the chain, threshold returns to 128.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_unit #(
	parameter int PALETTE_SIZE = npcm_pkg::PALETTE_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [npcm_pkg::THR_W-1:0] cfg_wdata,
	npcm_in_if.sink                    item,
	npcm_out_if.source                 result
);
	import npcm_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             adv;
	flow_t            head;
	flow_t            link [PALETTE_SIZE+1];
	flow_t            tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_comb begin
		head             = '0;
		head.vld         = item.valid;
		head.pixel       = item.action;
		head.entry_index = item.entry_index;
		head.entry_valid = item.entry_valid;
		head.red         = item.red;
		head.green       = item.green;
		head.blue        = item.blue;
		head.transp      = (item.action == ACT_PIXEL) && ({1'b0, item.alpha} < thr_q);
	end

	assign link[0] = head;

	for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
		npcm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_idx (IDX_W'(i)),
			.up       (link[i]),
			.dn       (link[i+1])
		);
	end

	assign tail = link[PALETTE_SIZE];

	// drop loads at the end of the chain, hold everything while a result waits
	assign result.valid         = tail.vld && (tail.pixel == ACT_PIXEL);
	assign result.transparent   = tail.transp;
	assign result.palette_index = tail.best_idx;
	assign result.distance      = tail.best_dist;
	assign result.found         = tail.found;

	assign adv        = !result.valid || result.ready;
	assign item.ready = adv;

	a_transp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.transparent |->
			!result.found && (result.distance == '0) && (result.palette_index == '0))
		else $error("transparent result carries a match");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |->
			(result.distance == '0) && (result.palette_index == '0))
		else $error("result without a match is not zero");

	a_stall_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(tail))
		else $error("chain moved during a stall");

endmodule

// File: design/npcm_cell.sv
// ----------------------------------------------------------------------------
// npcm_cell
// One palette slot: holds an entry, takes loads, updates the running best match.
// ----------------------------------------------------------------------------
module npcm_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [npcm_pkg::IDX_W-1:0]      cell_idx,
	input  npcm_pkg::flow_t                 up,
	output npcm_pkg::flow_t                 dn
);
	import npcm_pkg::*;

	logic [3*CH_W-1:0] ent_rgb_q;
	logic              ent_vld_q;
	flow_t             a_s1;
	logic              hit_s1;
	logic [SQ_W-1:0]   sq_r_s1;
	logic [SQ_W-1:0]   sq_g_s1;
	logic [SQ_W-1:0]   sq_b_s1;
	logic              wr;
	logic [DIST_W-1:0] sum;
	logic              take;
	flow_t             nxt_dn;

	assign wr = adv && up.vld && (up.pixel == ACT_LOAD) && (up.entry_index == cell_idx);

	// entry colour: no reset, only used once its valid mark is set
	always_ff @(posedge clk) begin
		if (wr) begin
			ent_rgb_q <= {up.red, up.green, up.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
		end else if (wr) begin
			ent_vld_q <= up.entry_valid;
		end
	end

	// stage 1: square the channel differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1    <= '0;
			hit_s1  <= 1'b0;
			sq_r_s1 <= '0;
			sq_g_s1 <= '0;
			sq_b_s1 <= '0;
		end else if (adv) begin
			a_s1    <= up;
			hit_s1  <= ent_vld_q;
			sq_r_s1 <= sq_diff(up.red,   ent_rgb_q[3*CH_W-1:2*CH_W]);
			sq_g_s1 <= sq_diff(up.green, ent_rgb_q[2*CH_W-1:CH_W]);
			sq_b_s1 <= sq_diff(up.blue,  ent_rgb_q[CH_W-1:0]);
		end
	end

	// stage 2: sum, compare, keep the lower index on a tie
	assign sum  = DIST_W'(sq_r_s1) + DIST_W'(sq_g_s1) + DIST_W'(sq_b_s1);
	assign take = a_s1.vld && (a_s1.pixel == ACT_PIXEL) && !a_s1.transp && hit_s1 &&
		(!a_s1.found || (sum < a_s1.best_dist));

	always_comb begin
		nxt_dn = a_s1;
		if (take) begin
			nxt_dn.found     = 1'b1;
			nxt_dn.best_dist = sum;
			nxt_dn.best_idx  = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn <= '0;
		end else if (adv) begin
			dn <= nxt_dn;
		end
	end

	a_no_found_when_transp: assert property (@(posedge clk) disable iff (!arst_n)
		dn.vld && dn.transp |-> !dn.found)
		else $error("match recorded for a transparent pixel");

	a_dist_never_grows: assert property (@(posedge clk) disable iff (!arst_n)
		adv && a_s1.vld && a_s1.found |=> dn.best_dist <= $past(a_s1.best_dist))
		else $error("best distance grew in a cell");

	a_load_sets_mark: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> ent_vld_q == $past(up.entry_valid))
		else $error("load did not update the valid mark");

endmodule

// File: dv/tb_nearest_palette_color_mapper_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_mapper_unit
// Self-checking bench for the nearest palette colour mapper. A directed table
// covers the empty palette, alpha threshold edges, ties, invalidation and the
// largest distance. Random load/pixel traffic then runs under several alpha
// thresholds. The table or a local palette copy predicts each result; results
// are checked in order. The sender idles in bursts, and the receiver stalls
// on its own pattern, with one long hold-off that backs the chain up.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_mapper_unit;
	import npcm_pkg::*;

	localparam int PAL_N     = PALETTE_SIZE_DEF;
	localparam int DRAIN_CYC = 2 * PAL_N + 16;
	localparam int HOLD_CYC  = 1500;
	localparam int WDOG_LIM  = 20000;
	localparam int N_DIR     = 22;

	typedef struct packed {
		logic             act;
		logic [IDX_W-1:0] idx;
		logic             ev;
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		logic [CH_W-1:0]  a;
	} req_t;

	typedef struct packed {
		logic              transparent;
		logic [IDX_W-1:0]  palette_index;
		logic [DIST_W-1:0] distance;
		logic              found;
	} match_t;

	typedef struct packed {
		req_t   q;
		logic   typed;
		match_t m;
	} row_t;

	localparam row_t DIR_TAB [N_DIR] = '{
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd10,  8'd20,  8'd30,  8'd255}, 1'b1,
			'{1'b0, 8'd0,   18'd0,      1'b0}},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd10,  8'd20,  8'd30,  8'd0},   1'b1,
			'{1'b1, 8'd0,   18'd0,      1'b0}},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd10,  8'd20,  8'd30,  8'd127}, 1'b1,
			'{1'b1, 8'd0,   18'd0,      1'b0}},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd10,  8'd20,  8'd30,  8'd128}, 1'b1,
			'{1'b0, 8'd0,   18'd0,      1'b0}},
		'{'{ACT_LOAD,  8'd0,   1'b1, 8'd0,   8'd0,   8'd0,   8'd255}, 1'b0, '0},
		'{'{ACT_LOAD,  8'd255, 1'b1, 8'd255, 8'd255, 8'd255, 8'd0},   1'b0, '0},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
			'{1'b0, 8'd255, 18'd0,      1'b1}},
		'{'{ACT_PIXEL, 8'd255, 1'b1, 8'd0,   8'd0,   8'd0,   8'd255}, 1'b1,
			'{1'b0, 8'd0,   18'd0,      1'b1}},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd0,   8'd0,   8'd255, 8'd200}, 1'b1,
			'{1'b0, 8'd0,   18'd65025,  1'b1}},
		'{'{ACT_LOAD,  8'd5,   1'b1, 8'd0,   8'd0,   8'd0,   8'd128}, 1'b0, '0},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd1,   8'd1,   8'd1,   8'd255}, 1'b1,
			'{1'b0, 8'd0,   18'd3,      1'b1}},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd1,   8'd1,   8'd1,   8'd127}, 1'b1,
			'{1'b1, 8'd0,   18'd0,      1'b0}},
		'{'{ACT_LOAD,  8'd0,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd1,   8'd1,   8'd1,   8'd255}, 1'b1,
			'{1'b0, 8'd5,   18'd3,      1'b1}},
		'{'{ACT_LOAD,  8'd5,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
		'{'{ACT_LOAD,  8'd255, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0},   1'b0, '0},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd255, 8'd255, 8'd255, 8'd200}, 1'b1,
			'{1'b0, 8'd0,   18'd0,      1'b0}},
		'{'{ACT_LOAD,  8'd128, 1'b1, 8'd255, 8'd255, 8'd255, 8'd0},   1'b0, '0},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0,   8'd255}, 1'b1,
			'{1'b0, 8'd128, 18'd195075, 1'b1}},
		'{'{ACT_LOAD,  8'd64,  1'b1, 8'd0,   8'd255, 8'd0,   8'd0},   1'b0, '0},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd255, 8'd0,   8'd255, 8'd255}, 1'b0, '0},
		'{'{ACT_PIXEL, 8'd0,   1'b0, 8'd0,   8'd255, 8'd0,   8'd255}, 1'b1,
			'{1'b0, 8'd64,  18'd0,      1'b1}}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	npcm_in_if  req_if ();
	npcm_out_if res_if ();

	logic [CH_W-1:0]  pal_r [PAL_N];
	logic [CH_W-1:0]  pal_g [PAL_N];
	logic [CH_W-1:0]  pal_b [PAL_N];
	bit               pal_on [PAL_N];
	logic [THR_W-1:0] thr;

	match_t match_q [$];
	int     fails;
	int     burst_left;
	int     idle_cyc;
	bit     hold_req;

	nearest_palette_color_mapper_unit #(
		.PALETTE_SIZE(PAL_N)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (req_if),
		.result   (res_if)
	);

	always #2 clk = ~clk;

	function automatic match_t nearest_entry(input req_t q);
		match_t m;
		int     dr;
		int     dg;
		int     db;
		int     d;
		int     best;
		bit     any;
		m = '0;
		best = 0;
		any = 1'b0;
		if (q.a < thr) begin
			m.transparent = 1'b1;
			return m;
		end
		for (int i = 0; i < PAL_N; i++) begin
			if (pal_on[i]) begin
				dr = int'(q.r) - int'(pal_r[i]);
				dg = int'(q.g) - int'(pal_g[i]);
				db = int'(q.b) - int'(pal_b[i]);
				d = dr * dr + dg * dg + db * db;
				if (!any || d < best) begin
					best = d;
					m.palette_index = IDX_W'(i);
					any = 1'b1;
				end
			end
		end
		m.distance = DIST_W'(best);
		m.found = any;
		return m;
	endfunction

	task automatic send_req(input req_t q, input logic typed, input match_t typed_m);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_if.valid       <= 1'b1;
		req_if.action      <= q.act;
		req_if.entry_index <= q.idx;
		req_if.entry_valid <= q.ev;
		req_if.red         <= q.r;
		req_if.green       <= q.g;
		req_if.blue        <= q.b;
		req_if.alpha       <= q.a;
		do @(posedge clk); while (!req_if.ready);
		if (q.act == ACT_LOAD) begin
			if (int'(q.idx) < PAL_N) begin
				pal_r[q.idx]  = q.r;
				pal_g[q.idx]  = q.g;
				pal_b[q.idx]  = q.b;
				pal_on[q.idx] = q.ev;
			end
		end else begin
			match_q.insert(match_q.size(), typed ? typed_m : nearest_entry(q));
		end
	endtask

	task automatic run_random(input int n);
		req_t q;
		int   k;
		for (int j = 0; j < n; j++) begin
			q.act = ($urandom_range(0, 9) < 3) ? ACT_LOAD : ACT_PIXEL;
			q.idx = IDX_W'($urandom_range(0, 255));
			q.ev  = ($urandom_range(0, 4) != 0);
			q.r   = CH_W'($urandom_range(0, 255));
			q.g   = CH_W'($urandom_range(0, 255));
			q.b   = CH_W'($urandom_range(0, 255));
			q.a   = ($urandom_range(0, 1) == 0) ? CH_W'($urandom_range(0, 255))
				: CH_W'(255 - $urandom_range(0, 40));
			// steer half the pixels close to a palette colour
			if (q.act == ACT_PIXEL && $urandom_range(0, 1) == 1) begin
				k = $urandom_range(0, PAL_N - 1);
				q.r = pal_r[k] + CH_W'($urandom_range(0, 6)) - CH_W'(3);
				q.g = pal_g[k] + CH_W'($urandom_range(0, 6)) - CH_W'(3);
				q.b = pal_b[k] + CH_W'($urandom_range(0, 6)) - CH_W'(3);
			end
			send_req(q, 1'b0, '0);
		end
		req_if.valid <= 1'b0;
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] v);
		while (match_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr = v;
	endtask

	initial begin : receiver
		int         mode;
		int         mode_left;
		logic [15:0] pat;
		mode = 0;
		mode_left = 0;
		pat = 16'hb5c3;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(8, 200);
				pat = 16'($urandom_range(1, 65535));
			end
			mode_left--;
			case (mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= 1'($urandom_range(0, 1));
				default: begin
					res_if.ready <= pat[0];
					pat = {pat[0], pat[15:1]};
				end
			endcase
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		match_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (match_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result t=%0b idx=%0d dist=%0d found=%0b",
						res_if.transparent, res_if.palette_index, res_if.distance,
						res_if.found);
			end else begin
				want = match_q.pop_front();
				if (res_if.transparent !== want.transparent
					|| res_if.palette_index !== want.palette_index
					|| res_if.distance !== want.distance
					|| res_if.found !== want.found) begin
					fails++;
					if (fails <= 10)
						$display("mismatch exp t=%0b idx=%0d dist=%0d found=%0b, %s",
							want.transparent, want.palette_index, want.distance,
							want.found,
							$sformatf("got t=%0b idx=%0d dist=%0d found=%0b",
								res_if.transparent, res_if.palette_index,
								res_if.distance, res_if.found));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WDOG_LIM) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		fails = 0;
		burst_left = 0;
		idle_cyc = 0;
		hold_req = 1'b0;
		thr = THR_RESET;
		for (int i = 0; i < PAL_N; i++) begin
			pal_on[i] = 1'b0;
			pal_r[i]  = '0;
			pal_g[i]  = '0;
			pal_b[i]  = '0;
		end
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= THR_RESET;
		req_if.valid       <= 1'b0;
		req_if.action      <= ACT_LOAD;
		req_if.entry_index <= '0;
		req_if.entry_valid <= 1'b0;
		req_if.red         <= '0;
		req_if.green       <= '0;
		req_if.blue        <= '0;
		req_if.alpha       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_req(DIR_TAB[i].q, DIR_TAB[i].typed, DIR_TAB[i].m);

		// hold the result side while requests keep coming
		hold_req = 1'b1;
		run_random(700);
		set_threshold(THR_W'(0));
		run_random(200);
		set_threshold(THR_W'(256));
		run_random(80);
		set_threshold(THR_W'(255));
		run_random(150);
		set_threshold(THR_W'(1));
		run_random(120);
		set_threshold(THR_W'($urandom_range(2, 254)));
		run_random(150);
		set_threshold(THR_RESET);
		run_random(80);

		while (match_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fails == 0 && match_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
